@@ hdl/bloom_filter_engine_macros.svh @@
// assertion helpers used by the bloom_filter_engine rtl
`ifndef BLOOM_FILTER_ENGINE_MACROS_SVH
`define BLOOM_FILTER_ENGINE_MACROS_SVH

`ifndef SYNTH

`define BF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bloom filter assertion failed");

`define BF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bloom filter assertion failed");

`else

`define BF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define BF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/bf_pkg.sv @@
`default_nettype none

package bf_pkg;

    localparam int HASH_W    = 32;
    localparam int DIGIT_W   = 4;
    localparam int MOD_STEPS = HASH_W / DIGIT_W;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    localparam logic [HASH_W-1:0] MUL_FIRST  = 32'd31;
    localparam logic [HASH_W-1:0] MUL_SECOND = 32'd37;

    localparam logic [4:0]  PROBE_LIMIT      = 5'd30;
    localparam logic [4:0]  HASH_COUNT_RST   = 5'd6;
    localparam logic [14:0] FILTER_BYTES_RST = 15'd12500;

    localparam logic CFG_HASH_COUNT   = 1'b0;
    localparam logic CFG_FILTER_BYTES = 1'b1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD_START,
        S_MOD_WAIT,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_store_cmd;

endpackage

`default_nettype wire

@@ hdl/bloom_filter_engine.sv @@
// bloom_filter_engine: bloom filter with double hashing over keys streamed a byte per item.
// input channel: i_in_valid / o_in_stall with i_opcode, i_key_byte, i_byte_valid,
// i_last_byte. a key is a run of items ending in one with i_last_byte set; only the
// opcode of that last item counts (0 add, 1 query).
// output channel: o_out_valid / i_out_stall with o_may_contain, o_was_query; exactly
// one result per key, none for the other items.
// config channel: i_cfg_valid / o_cfg_ready, index 0 hash_count, index 1 filter_bytes.
// a non-last item is taken without leaving the idle state. a last item runs its probes one
// after another through a single shared modulo unit that retires four bits of the 32-bit
// probe per cycle; each probe passes start, 8 modulo steps, done, store read and
// check/write, after the item is taken and before the result is handed over.
// a query stops at the first clear bit. the store is a single-port byte memory.
// after reset the store is swept to zero, one byte per cycle, and no item is taken
// meanwhile; configuration writes are taken at any time.
// the result sits in an output register; while the receiver stalls it holds, items
// that do not end a key are still taken, and a finished key waits for the register.
`default_nettype none
`include "bloom_filter_engine_macros.svh"

module bloom_filter_engine
    import bf_pkg::*;
#(
    parameter int MAX_BYTES = 16384
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_opcode,
    input  wire logic [7:0]  i_key_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_may_contain,
    output logic             o_was_query,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);

    localparam int EFF_BYTES = (MAX_BYTES < 32767) ? MAX_BYTES : 32767;
    localparam int NB_W      = $clog2(EFF_BYTES * 8 + 1);
    localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    t_state            r_state;
    t_state            n_state;
    logic [4:0]        r_hash_count;
    logic [14:0]       r_filter_bytes;
    logic [HASH_W-1:0] r_probe;
    logic [HASH_W-1:0] n_probe;
    logic [HASH_W-1:0] r_step;
    logic [HASH_W-1:0] n_step;
    logic [NB_W-1:0]   r_nbits;
    logic [NB_W-1:0]   n_nbits;
    logic [4:0]        r_total;
    logic [4:0]        n_total;
    logic [4:0]        r_cnt;
    logic [4:0]        n_cnt;
    logic              r_query;
    logic              n_query;
    logic              r_all_set;
    logic              n_all_set;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_may_contain;
    logic              n_may_contain;
    logic              r_was_query;
    logic              n_was_query;

    logic              w_accept;
    logic [HASH_W-1:0] w_h1;
    logic [HASH_W-1:0] w_h2;
    logic [14:0]       w_nbytes;
    logic [4:0]        w_total;
    logic              w_mod_start;
    logic              w_mod_done;
    logic [NB_W-1:0]   w_rem;
    t_store_cmd        w_cmd;
    logic [ADDR_W-1:0] w_addr;
    logic [7:0]        w_wdata;
    logic [7:0]        w_rdata;
    logic              w_store_busy;
    logic              w_bit;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count   <= HASH_COUNT_RST;
            r_filter_bytes <= FILTER_BYTES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_HASH_COUNT) begin
                r_hash_count <= i_cfg_data[4:0];
            end else begin
                r_filter_bytes <= i_cfg_data;
            end
        end
    end

    bf_hash u_hash (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_key_byte    (i_key_byte),
        .i_byte_valid  (i_byte_valid),
        .i_last_byte   (i_last_byte),
        .o_first_hash  (w_h1),
        .o_second_hash (w_h2)
    );

    bf_mod #(
        .NB_W (NB_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_probe),
        .i_divisor  (r_nbits),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    bf_store #(
        .MAX_BYTES (MAX_BYTES),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata),
        .o_busy  (w_store_busy)
    );

    assign w_nbytes = (32'(r_filter_bytes) > MAX_BYTES) ? 15'(MAX_BYTES) : r_filter_bytes;
    assign w_total  = (r_hash_count > PROBE_LIMIT) ? PROBE_LIMIT : r_hash_count;
    assign w_addr   = ADDR_W'(w_rem[NB_W-1:3]);
    assign w_bit    = w_rdata[w_rem[2:0]];
    assign w_wdata  = w_rdata | (8'b1 << w_rem[2:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe       <= n_probe;
        r_step        <= n_step;
        r_nbits       <= n_nbits;
        r_total       <= n_total;
        r_cnt         <= n_cnt;
        r_query       <= n_query;
        r_all_set     <= n_all_set;
        r_may_contain <= n_may_contain;
        r_was_query   <= n_was_query;
    end

    always_comb begin
        n_state       = r_state;
        n_probe       = r_probe;
        n_step        = r_step;
        n_nbits       = r_nbits;
        n_total       = r_total;
        n_cnt         = r_cnt;
        n_query       = r_query;
        n_all_set     = r_all_set;
        n_out_valid   = r_out_valid;
        n_may_contain = r_may_contain;
        n_was_query   = r_was_query;
        o_in_stall    = 1'b1;
        w_mod_start   = 1'b0;
        w_cmd         = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                if (!w_store_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_last_byte) begin
                    n_probe   = w_h1;
                    n_step    = w_h2;
                    n_nbits   = NB_W'({w_nbytes, 3'b000});
                    n_total   = w_total;
                    n_cnt     = '0;
                    n_query   = (i_opcode == OP_QUERY);
                    n_all_set = 1'b1;
                    if (w_total == '0 || w_nbytes == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_MOD_START;
                    end
                end
            end
            S_MOD_START: begin
                w_mod_start = 1'b1;
                n_state     = S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
                if (w_mod_done) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                n_cnt   = r_cnt + 1'b1;
                n_probe = r_probe + r_step;
                if (r_query) begin
                    if (!w_bit) begin
                        n_all_set = 1'b0;
                        n_state   = S_FINISH;
                    end else if (n_cnt == r_total) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_MOD_START;
                    end
                end else begin
                    w_cmd.wr = 1'b1;
                    if (n_cnt == r_total) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_MOD_START;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_may_contain = r_query && r_all_set;
                    n_was_query   = r_query;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_may_contain = r_may_contain;
    assign o_was_query   = r_was_query;

    `BF_ASSERT_IMPLIES(a_mod_done_in_wait, i_clk, i_rst_n, w_mod_done, r_state == S_MOD_WAIT)
    `BF_ASSERT_IMPLIES(a_rem_in_range, i_clk, i_rst_n, w_mod_done, w_rem < r_nbits)
    `BF_ASSERT_IMPLIES(a_write_only_add, i_clk, i_rst_n, w_cmd.wr, !r_query && !w_store_busy)
    `BF_ASSERT_IMPLIES(a_result_from_finish, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_FINISH)
    `BF_ASSERT_NEXT(a_mid_key_stays_idle, i_clk, i_rst_n, w_accept && !i_last_byte, r_state == S_IDLE)

endmodule

`default_nettype wire

@@ hdl/bf_hash.sv @@
`default_nettype none

module bf_hash
    import bf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_key_byte,
    input  wire logic              i_byte_valid,
    input  wire logic              i_last_byte,
    output logic      [HASH_W-1:0] o_first_hash,
    output logic      [HASH_W-1:0] o_second_hash
);

    logic [HASH_W-1:0] r_h1;
    logic [HASH_W-1:0] r_h2;
    logic [HASH_W-1:0] n_h1;
    logic [HASH_W-1:0] n_h2;

    // hashes including the byte being accepted
    always_comb begin
        n_h1 = r_h1;
        n_h2 = r_h2;
        if (i_byte_valid) begin
            n_h1 = HASH_W'(r_h1 * MUL_FIRST) + HASH_W'(i_key_byte);
            n_h2 = HASH_W'(r_h2 * MUL_SECOND) + HASH_W'(i_key_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1 <= '0;
            r_h2 <= '0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_h1 <= '0;
                r_h2 <= '0;
            end else begin
                r_h1 <= n_h1;
                r_h2 <= n_h2;
            end
        end
    end

    assign o_first_hash  = n_h1;
    assign o_second_hash = n_h2;

endmodule

`default_nettype wire

@@ hdl/bf_mod.sv @@
`default_nettype none

module bf_mod
    import bf_pkg::*;
#(
    parameter int NB_W = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASH_W-1:0] i_dividend,
    input  wire logic [NB_W-1:0]   i_divisor,
    output logic                   o_done,
    output logic      [NB_W-1:0]   o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [HASH_W-1:0] r_dvd;
    logic [NB_W-1:0]   r_div;
    logic [NB_W-1:0]   r_rem;
    logic [NB_W-1:0]   n_rem;
    logic [NB_W:0]     w_trial;

    // restoring remainder, several dividend bits per cycle
    always_comb begin
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < DIGIT_W; k++) begin
            w_trial = {n_rem, r_dvd[HASH_W-1-k]};
            if (w_trial >= {1'b0, r_div}) begin
                w_trial = w_trial - {1'b0, r_div};
            end
            n_rem = w_trial[NB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[HASH_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

@@ hdl/bf_store.sv @@
`default_nettype none

module bf_store
    import bf_pkg::*;
#(
    parameter int MAX_BYTES = 16384,
    parameter int ADDR_W    = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_store_cmd        i_cmd,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [7:0]        i_wdata,
    output logic      [7:0]        o_rdata,
    output logic                   o_busy
);

    logic [7:0]        r_mem [MAX_BYTES];
    logic [7:0]        r_rdata;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    // one byte cleared per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(MAX_BYTES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bf_pkg::*;

    localparam int STORE_BYTES   = 16384;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_ITEMS   = 180;
    localparam int PHASES        = 6;

    typedef struct packed {
        logic may_contain;
        logic was_query;
    } t_answer;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  len;
    } t_key;

    class t_filter_shadow;
        logic [4:0]  probe_cfg;
        logic [14:0] size_cfg;
        logic [31:0] hash31;
        logic [31:0] hash37;
        logic [7:0]  store [STORE_BYTES];
        t_answer     pending [$];
        int          errors;

        function new();
            probe_cfg = HASH_COUNT_RST;
            size_cfg  = FILTER_BYTES_RST;
            hash31    = '0;
            hash37    = '0;
            errors    = 0;
            foreach (store[j]) store[j] = 8'h00;
        endfunction

        function void write_reg(logic idx, logic [14:0] data);
            if (idx == CFG_HASH_COUNT) begin
                probe_cfg = data[4:0];
            end else begin
                size_cfg = data;
            end
        endfunction

        // fold one accepted item into the hashes, probe the store at the end of a key
        function void take_byte(logic op, logic [7:0] kb, logic bv, logic last);
            int unsigned used;
            int unsigned count;
            int unsigned i;
            logic [31:0] nbits;
            logic [31:0] probe;
            logic [31:0] pos;
            logic        hit;
            t_answer     ans;
            if (bv) begin
                hash31 = hash31 * MUL_FIRST + {24'd0, kb};
                hash37 = hash37 * MUL_SECOND + {24'd0, kb};
            end
            if (!last) return;
            used  = (size_cfg > STORE_BYTES) ? STORE_BYTES : size_cfg;
            count = (probe_cfg > PROBE_LIMIT) ? PROBE_LIMIT : probe_cfg;
            hit   = 1'b1;
            if (used != 0) begin
                nbits = used * 8;
                for (i = 0; i < count; i++) begin
                    probe = hash31 + i * hash37;
                    pos   = probe % nbits;
                    if (op == OP_QUERY) begin
                        if (!store[pos[31:3]][pos[2:0]]) begin
                            hit = 1'b0;
                            break;
                        end
                    end else begin
                        store[pos[31:3]][pos[2:0]] = 1'b1;
                    end
                end
            end
            ans.was_query   = (op == OP_QUERY);
            ans.may_contain = (op == OP_QUERY) ? hit : 1'b0;
            pending.insert(pending.size(), ans);
            hash31 = '0;
            hash37 = '0;
        endfunction

        function void check_answer(logic mc, logic wq);
            t_answer want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result may_contain=%0b was_query=%0b", $time, mc, wq);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (mc !== want.may_contain) begin
                $display("%0t: may_contain expected %0b actual %0b",
                         $time, want.may_contain, mc);
                errors++;
            end
            if (wq !== want.was_query) begin
                $display("%0t: was_query expected %0b actual %0b", $time, want.was_query, wq);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [7:0]  i_key_byte;
    logic        i_byte_valid;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_may_contain;
    logic        o_was_query;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [14:0] i_cfg_data;

    t_filter_shadow shadow;
    t_key           known [$];
    int             send_idle;
    int             recv_idle;
    int             items_sent;
    int             cycles;
    logic [4:0]     probe_plan [PHASES];
    logic [14:0]    size_plan [PHASES];

    bloom_filter_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_key_byte    (i_key_byte),
        .i_byte_valid  (i_byte_valid),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_may_contain (o_may_contain),
        .o_was_query   (o_was_query),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            shadow.check_answer(o_may_contain, o_was_query);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] kb, input logic bv,
                             input logic last);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_opcode     = op;
        i_key_byte   = kb;
        i_byte_valid = bv;
        i_last_byte  = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.take_byte(op, kb, bv, last);
        if (bv || last) items_sent++;
        @(negedge i_clk);
    endtask

    // noisy keys get ignored items in between, random opcodes on the early bytes
    // and sometimes an empty closing item
    task automatic send_key(input logic op, input t_key k, input bit noisy);
        int   n;
        logic tail_empty;
        logic this_op;
        tail_empty = (k.len == 0) || (noisy && $urandom_range(4) == 0);
        for (n = 0; n < k.len; n++) begin
            if (noisy && $urandom_range(9) == 0) begin
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
            end
            this_op = (noisy && n != k.len - 1) ? 1'($urandom_range(1)) : op;
            send_item(this_op, k.data[8*n +: 8], 1'b1, (n == k.len - 1) && !tail_empty);
        end
        if (tail_empty) begin
            send_item(op, 8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    function automatic t_key random_key();
        t_key k;
        int   n;
        k.len  = ($urandom_range(15) == 0) ? 4'd0 : 4'($urandom_range(1, 8));
        k.data = {$urandom, $urandom};
        if ($urandom_range(3) == 0) begin
            for (n = 0; n < 8; n++) k.data[8*n +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return k;
    endfunction

    task automatic settle();
        i_in_valid = 1'b0;
        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [14:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic directed_keys();
        t_key k;
        k.data = '0;
        k.len  = 0;
        send_key(OP_QUERY, k, 1'b0);
        send_key(OP_ADD, k, 1'b0);
        send_key(OP_QUERY, k, 1'b0);
        k.len = 1;
        send_key(OP_QUERY, k, 1'b0);
        k.data = {8{8'hFF}};
        k.len  = 8;
        send_key(OP_ADD, k, 1'b0);
        send_key(OP_QUERY, k, 1'b0);
        k.data = 64'h5AA5;
        k.len  = 2;
        send_key(OP_QUERY, k, 1'b0);
        // ignored item, query opcode on early bytes, key closed by an empty add
        send_item(OP_QUERY, 8'h5A, 1'b0, 1'b0);
        send_item(OP_QUERY, 8'hA5, 1'b1, 1'b0);
        send_item(OP_QUERY, 8'h5A, 1'b1, 1'b0);
        send_item(OP_ADD, 8'h00, 1'b0, 1'b1);
        send_item(OP_ADD, 8'hA5, 1'b1, 1'b0);
        send_item(OP_ADD, 8'h5A, 1'b1, 1'b0);
        send_item(OP_QUERY, 8'hFF, 1'b0, 1'b1);
    endtask

    initial begin
        int         p;
        int         r;
        int         phase_end;
        logic [9:0] pad;
        t_key       k;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_ADD;
        i_key_byte   = 8'h00;
        i_byte_valid = 1'b0;
        i_last_byte  = 1'b0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_HASH_COUNT;
        i_cfg_data   = '0;
        items_sent   = 0;
        cycles       = 0;
        send_idle    = 24;
        recv_idle    = 72;
        probe_plan   = '{5'd1, 5'd30, 5'd31, 5'd0, 5'd7, 5'd12};
        size_plan    = '{15'd1, 15'd16384, 15'd32767, 15'd64, 15'd0, 15'd3};
        shadow       = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_keys();

        for (p = 0; p < PHASES; p++) begin
            settle();
            send_idle = (p / 2 == 0) ? 24 : (p / 2 == 1) ? 72 : 0;
            recv_idle = (p / 2 == 0) ? 72 : (p / 2 == 1) ? 24 : 0;
            pad = 10'($urandom_range(1023));
            if ($urandom_range(1)) begin
                write_cfg(CFG_HASH_COUNT, {pad, probe_plan[p]});
                write_cfg(CFG_FILTER_BYTES, size_plan[p]);
            end else begin
                write_cfg(CFG_FILTER_BYTES, size_plan[p]);
                write_cfg(CFG_HASH_COUNT, {pad, probe_plan[p]});
            end
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                r = $urandom_range(99);
                if (r < 35 || known.size() == 0) begin
                    k = random_key();
                    send_key(OP_ADD, k, $urandom_range(3) == 0);
                    known.insert(known.size(), k);
                    if (known.size() > 48) known.delete(0);
                end else if (r < 65) begin
                    k = known[$urandom_range(known.size() - 1)];
                    send_key(OP_QUERY, k, 1'b0);
                end else if (r < 90) begin
                    send_key(OP_QUERY, random_key(), $urandom_range(3) == 0);
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                                  1'($urandom_range(1)), 1'b0);
                    end
                end
            end
            send_key(OP_QUERY, random_key(), 1'b0);
        end

        settle();
        if (shadow.errors == 0 && shadow.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
